>>> design/csrg_pkg.sv
// Package for the CSR graph builder and query block.
// Holds field widths, status and function codes, unit opcodes and the store strobe struct.
// Depends on nothing; every other design file imports it.
`default_nettype none

package csrg_pkg;

	// Default sizes for the top-level parameters.
	localparam int MAX_NODES_DEF = 64;
	localparam int EDGE_CAP_DEF  = 4096;
	localparam int UNIT_W_DEF    = 13;

	// Fixed field widths of the transaction payloads.
	localparam int NODE_W       = 6;
	localparam int COUNT_W      = 7;
	localparam int DEG_W        = 7;
	localparam int EDGE_TOTAL_W = 13;
	localparam int STATUS_W     = 2;

	// Register port.
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_NODE_COUNT = 1'b0;
	localparam logic [COUNT_W-1:0] NODE_COUNT_RST = 7'd64;

	// Input function codes.
	localparam logic FUNC_LOAD  = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Result status codes.
	localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NO_GRAPH = 2'd2;

	// Operations of the shared step unit.
	typedef enum logic [1:0] {
		UOP_ADD,
		UOP_SUB,
		UOP_HALF
	} unit_op_t;

	// Write strobes from the sequencer to the graph stores.
	typedef struct packed {
		logic col_we;
		logic rs_we;
		logic deg_we;
		logic deg_clr;
	} store_wr_t;

	function automatic int max2(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

endpackage

`default_nettype wire

>>> design/csrg_unit.sv
// Shared step unit of the CSR graph block: an adder with add and midpoint operations, a
// subtractor and one magnitude comparator. Depends on csrg_pkg.
`default_nettype none

module csrg_unit
	import csrg_pkg::*;
#(
	parameter int W = UNIT_W_DEF
) (
	input  wire unit_op_t       op,
	input  wire logic [W-1:0]   a,
	input  wire logic [W-1:0]   b,
	input  wire logic [W-1:0]   c,
	input  wire logic [W-1:0]   d,
	output logic      [W-1:0]   res,
	output logic                eq,
	output logic                lt
);

	logic [W:0] sum;

	assign sum = {1'b0, a} + {1'b0, b};

	always_comb begin
		case (op)
			UOP_ADD:  res = sum[W-1:0];
			UOP_SUB:  res = a - b;
			UOP_HALF: res = sum[W:1];
			default:  res = sum[W-1:0];
		endcase
	end

	assign eq = (c == d);
	assign lt = (c < d);

endmodule

`default_nettype wire

>>> design/csrg_store.sv
// Graph stores of the CSR block: column store, row start store and in-degree counters
// with per-entry valid bits. All reads are registered. Depends on csrg_pkg.
`default_nettype none

module csrg_store
	import csrg_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_DEF,
	parameter int EDGE_CAP  = EDGE_CAP_DEF,
	localparam int AW  = $clog2(EDGE_CAP),
	localparam int EW  = $clog2(EDGE_CAP + 1),
	localparam int NIW = $clog2(MAX_NODES),
	localparam int NCW = $clog2(MAX_NODES + 1)
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire store_wr_t       wr,
	input  wire logic [AW-1:0]   col_waddr,
	input  wire logic [NIW-1:0]  col_wdata,
	input  wire logic [AW-1:0]   col_raddr,
	output logic      [NIW-1:0]  col_rdata,
	input  wire logic [NCW-1:0]  rs_waddr,
	input  wire logic [EW-1:0]   rs_wdata,
	input  wire logic [NCW-1:0]  rs_raddr,
	output logic      [EW-1:0]   rs_rdata,
	input  wire logic [NIW-1:0]  deg_waddr,
	input  wire logic [NCW-1:0]  deg_wdata,
	input  wire logic [NIW-1:0]  deg_raddr,
	output logic      [NCW-1:0]  deg_rdata
);

	logic [NIW-1:0] col_mem [EDGE_CAP];
	logic [EW-1:0]  rs_mem  [MAX_NODES + 1];
	logic [NCW-1:0] deg_mem [MAX_NODES];

	logic [MAX_NODES-1:0] deg_vld_q;
	logic [NIW-1:0]       col_rdata_q;
	logic [EW-1:0]        rs_rdata_q;
	logic [NCW-1:0]       deg_rdata_q;

	always_ff @(posedge clk) begin
		if (wr.col_we) begin
			col_mem[col_waddr] <= col_wdata;
		end
		col_rdata_q <= col_mem[col_raddr];
	end

	always_ff @(posedge clk) begin
		if (wr.rs_we) begin
			rs_mem[rs_waddr] <= rs_wdata;
		end
		rs_rdata_q <= rs_mem[rs_raddr];
	end

	always_ff @(posedge clk) begin
		if (wr.deg_we) begin
			deg_mem[deg_waddr] <= deg_wdata;
		end
		deg_rdata_q <= deg_vld_q[deg_raddr] ? deg_mem[deg_raddr] : '0;
	end

	// A counter that has not been written since the last clear reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_vld_q <= '0;
		end else if (wr.deg_clr) begin
			deg_vld_q <= '0;
		end else if (wr.deg_we) begin
			deg_vld_q[deg_waddr] <= 1'b1;
		end
	end

	assign col_rdata = col_rdata_q;
	assign rs_rdata  = rs_rdata_q;
	assign deg_rdata = deg_rdata_q;

endmodule

`default_nettype wire

>>> design/csr_graph_builder_and_query.sv
// Top level of the CSR graph builder and query block: sequencer, register port,
// output register. Depends on csrg_pkg, csrg_unit and csrg_store.
`default_nettype none

//  Channel   Direction  Handshake              Payload
//  config    in/out     psel/penable/pready    paddr, pwdata, prdata (node_count)
//  input     in         in_valid/in_ready      func, adj_bit, from_node, to_node
//  result    out        out_valid/out_ready    status, has_edge, out_degree, in_degree,
//                                              edge_total, load_done
//
// One transaction is worked on at a time; in_ready is high only while the sequencer idles.
// A load transaction steps through S_L_RD, S_L_INC and S_L_CNT to S_FIN, from which
// the result register is loaded. A query with an error status goes straight to S_FIN.
// A valid query steps through S_Q_LO, S_Q_HI, S_Q_DEG, then S_Q_MID and S_Q_CMP for each
// binary search step, as the column store has one read port and the comparator is shared.
// The result register lets the next transaction start while the previous result waits;
// a finished result waits in the last sequencer state while the register is still full.
// Reset clears the load position, edge count and graph flag and sets node_count to 64.
// Store contents need no clearing pass; in-degree counters carry valid bits instead.

module csr_graph_builder_and_query
	import csrg_pkg::*;
#(
	parameter int MAX_NODES = MAX_NODES_DEF,
	parameter int EDGE_CAP  = EDGE_CAP_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	// Register port
	input  wire logic                    psel,
	input  wire logic                    penable,
	input  wire logic                    pwrite,
	input  wire logic [ADDR_W-1:0]       paddr,
	input  wire logic [DATA_W-1:0]       pwdata,
	output logic      [DATA_W-1:0]       prdata,
	output logic                         pready,
	// Input channel
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic                    func,
	input  wire logic                    adj_bit,
	input  wire logic [NODE_W-1:0]       from_node,
	input  wire logic [NODE_W-1:0]       to_node,
	// Result channel
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic      [STATUS_W-1:0]     status,
	output logic                         has_edge,
	output logic      [DEG_W-1:0]        out_degree,
	output logic      [DEG_W-1:0]        in_degree,
	output logic      [EDGE_TOTAL_W-1:0] edge_total,
	output logic                         load_done
);

	localparam int EW   = $clog2(EDGE_CAP + 1);
	localparam int AW   = $clog2(EDGE_CAP);
	localparam int NCW  = $clog2(MAX_NODES + 1);
	localparam int NIW  = $clog2(MAX_NODES);
	localparam int KW   = max2(NIW, NODE_W);
	localparam int CMPW = max2(NCW, COUNT_W);
	localparam int UW   = max2(max2(EW, NCW), KW);

	typedef enum logic [9:0] {
		S_IDLE  = 10'b0000000001,
		S_L_RD  = 10'b0000000010,
		S_L_INC = 10'b0000000100,
		S_L_CNT = 10'b0000001000,
		S_Q_LO  = 10'b0000010000,
		S_Q_HI  = 10'b0000100000,
		S_Q_DEG = 10'b0001000000,
		S_Q_MID = 10'b0010000000,
		S_Q_CMP = 10'b0100000000,
		S_FIN   = 10'b1000000000
	} state_t;

	state_t state_q;

	// Control state.
	logic [COUNT_W-1:0] node_count_q;
	logic [NCW-1:0]     load_row_q;
	logic [NCW-1:0]     load_col_q;
	logic [EW-1:0]      edge_count_q;
	logic               graph_valid_q;
	logic               out_valid_q;

	// Working registers of the current transaction.
	logic               bit_q;
	logic [NODE_W-1:0]  from_q;
	logic [NODE_W-1:0]  key_q;
	logic               store_ok_q;
	logic [EW-1:0]      lo_q;
	logic [EW-1:0]      hi_q;
	logic [EW-1:0]      mid_q;
	logic [EW-1:0]      outd_q;
	logic [NCW-1:0]     ind_q;
	logic               has_q;
	logic [STATUS_W-1:0] status_q;
	logic               done_q;

	// Result register.
	logic [STATUS_W-1:0]     out_status_q;
	logic                    out_has_q;
	logic [DEG_W-1:0]        out_outd_q;
	logic [DEG_W-1:0]        out_ind_q;
	logic [EDGE_TOTAL_W-1:0] out_total_q;
	logic                    out_done_q;

	// Shared step unit.
	unit_op_t      u_op;
	logic [UW-1:0] u_a;
	logic [UW-1:0] u_b;
	logic [UW-1:0] u_c;
	logic [UW-1:0] u_d;
	logic [UW-1:0] u_res;
	logic          u_eq;
	logic          u_lt;

	// Store interface.
	store_wr_t      st_wr;
	logic [AW-1:0]  col_waddr;
	logic [NIW-1:0] col_wdata;
	logic [AW-1:0]  col_raddr;
	logic [NIW-1:0] col_rdata;
	logic [NCW-1:0] rs_waddr;
	logic [EW-1:0]  rs_wdata;
	logic [NCW-1:0] rs_raddr;
	logic [EW-1:0]  rs_rdata;
	logic [NIW-1:0] deg_waddr;
	logic [NCW-1:0] deg_wdata;
	logic [NIW-1:0] deg_raddr;
	logic [NCW-1:0] deg_rdata;

	logic           cfg_wr;
	logic           in_acc;
	logic           out_load;
	logic [NCW-1:0] n_act;
	logic           pos_wrap;
	logic [NCW-1:0] eff_row;
	logic [NCW-1:0] eff_col;
	logic           load_start;
	logic           range_bad;
	logic [NCW-1:0] col_next;
	logic [NCW-1:0] row_next;
	logic           col_wrap;
	logic           row_wrap;

	// ------------------------------------------------------------------
	// Register port. Only node_count exists; any write to it also drops a
	// load in progress and invalidates the stored graph.
	// ------------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready
		&& (paddr[ADDR_W-1:2] == REG_NODE_COUNT);

	always_comb begin
		prdata = '0;
		if (paddr[ADDR_W-1:2] == REG_NODE_COUNT) begin
			prdata = DATA_W'(node_count_q);
		end
	end

	// Nodes in use: a count of zero acts as one, and a count above the store size is capped.
	always_comb begin
		if (node_count_q == '0) begin
			n_act = NCW'(1);
		end else if (CMPW'(node_count_q) > CMPW'(MAX_NODES)) begin
			n_act = NCW'(MAX_NODES);
		end else begin
			n_act = NCW'(node_count_q);
		end
	end

	// ------------------------------------------------------------------
	// Load position. A position left outside the matrix folds back to the
	// origin, and a load at the origin starts a fresh graph.
	// ------------------------------------------------------------------
	assign pos_wrap   = (load_row_q >= n_act) || (load_col_q >= n_act);
	assign eff_row    = pos_wrap ? '0 : load_row_q;
	assign eff_col    = pos_wrap ? '0 : load_col_q;
	assign load_start = (eff_row == '0) && (eff_col == '0);

	assign col_next = load_col_q + NCW'(1);
	assign row_next = load_row_q + NCW'(1);
	assign col_wrap = (col_next >= n_act);
	assign row_wrap = col_wrap && (row_next >= n_act);

	assign range_bad = (CMPW'(from_node) >= CMPW'(n_act)) || (CMPW'(to_node) >= CMPW'(n_act));

	assign in_ready = (state_q == S_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_load = (state_q == S_FIN) && (!out_valid_q || out_ready);

	// ------------------------------------------------------------------
	// Datapath steering: each sequencer state decides what the shared
	// unit computes and which store ports are active.
	// ------------------------------------------------------------------
	always_comb begin
		st_wr     = '0;
		col_waddr = edge_count_q[AW-1:0];
		col_wdata = load_col_q[NIW-1:0];
		col_raddr = u_res[AW-1:0];
		rs_waddr  = eff_row;
		rs_wdata  = load_start ? '0 : edge_count_q;
		rs_raddr  = NCW'(from_q);
		deg_waddr = load_col_q[NIW-1:0];
		deg_wdata = u_res[NCW-1:0];
		deg_raddr = load_col_q[NIW-1:0];
		u_op      = UOP_ADD;
		u_a       = '0;
		u_b       = '0;
		u_c       = '0;
		u_d       = '0;
		case (state_q)
			S_IDLE: begin
				// The first bit of a row records where that row starts.
				if (in_acc && func == FUNC_LOAD) begin
					st_wr.deg_clr = load_start;
					st_wr.rs_we   = (eff_col == '0);
				end
			end
			S_L_RD: begin
				u_c = UW'(edge_count_q);
				u_d = UW'(EDGE_CAP);
			end
			S_L_INC: begin
				u_a          = UW'(deg_rdata);
				u_b          = UW'(1);
				st_wr.deg_we = store_ok_q;
				st_wr.col_we = store_ok_q;
			end
			S_L_CNT: begin
				// The last bit of the matrix closes the final row.
				u_a         = UW'(edge_count_q);
				u_b         = UW'(store_ok_q);
				st_wr.rs_we = row_wrap;
				rs_waddr    = n_act;
				rs_wdata    = u_res[EW-1:0];
			end
			S_Q_HI: begin
				rs_raddr  = NCW'(from_q) + NCW'(1);
				deg_raddr = NIW'(from_q);
			end
			S_Q_DEG: begin
				u_op = UOP_SUB;
				u_a  = UW'(rs_rdata);
				u_b  = UW'(lo_q);
			end
			S_Q_MID: begin
				u_op = UOP_HALF;
				u_a  = UW'(lo_q);
				u_b  = UW'(hi_q);
				u_c  = UW'(lo_q);
				u_d  = UW'(hi_q);
			end
			S_Q_CMP: begin
				u_a = UW'(mid_q);
				u_b = UW'(1);
				u_c = UW'(col_rdata);
				u_d = UW'(key_q);
			end
			default: begin
			end
		endcase
	end

	csrg_unit #(
		.W (UW)
	) u_unit (
		.op  (u_op),
		.a   (u_a),
		.b   (u_b),
		.c   (u_c),
		.d   (u_d),
		.res (u_res),
		.eq  (u_eq),
		.lt  (u_lt)
	);

	csrg_store #(
		.MAX_NODES (MAX_NODES),
		.EDGE_CAP  (EDGE_CAP)
	) u_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr        (st_wr),
		.col_waddr (col_waddr),
		.col_wdata (col_wdata),
		.col_raddr (col_raddr),
		.col_rdata (col_rdata),
		.rs_waddr  (rs_waddr),
		.rs_wdata  (rs_wdata),
		.rs_raddr  (rs_raddr),
		.rs_rdata  (rs_rdata),
		.deg_waddr (deg_waddr),
		.deg_wdata (deg_wdata),
		.deg_raddr (deg_raddr),
		.deg_rdata (deg_rdata)
	);

	// ------------------------------------------------------------------
	// Sequencer and control state.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			node_count_q  <= NODE_COUNT_RST;
			load_row_q    <= '0;
			load_col_q    <= '0;
			edge_count_q  <= '0;
			graph_valid_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_wr) begin
				node_count_q  <= pwdata[COUNT_W-1:0];
				load_row_q    <= '0;
				load_col_q    <= '0;
				edge_count_q  <= '0;
				graph_valid_q <= 1'b0;
			end else begin
				case (state_q)
					S_IDLE: begin
						if (in_acc) begin
							if (func == FUNC_LOAD) begin
								load_row_q <= eff_row;
								load_col_q <= eff_col;
								if (load_start) begin
									edge_count_q  <= '0;
									graph_valid_q <= 1'b0;
								end
								state_q <= S_L_RD;
							end else if (!graph_valid_q || range_bad) begin
								state_q <= S_FIN;
							end else begin
								state_q <= S_Q_LO;
							end
						end
					end
					S_L_RD:  state_q <= S_L_INC;
					S_L_INC: state_q <= S_L_CNT;
					S_L_CNT: begin
						edge_count_q <= u_res[EW-1:0];
						if (col_wrap) begin
							load_col_q <= '0;
							if (row_wrap) begin
								load_row_q    <= '0;
								graph_valid_q <= 1'b1;
							end else begin
								load_row_q <= row_next;
							end
						end else begin
							load_col_q <= col_next;
						end
						state_q <= S_FIN;
					end
					S_Q_LO:  state_q <= S_Q_HI;
					S_Q_HI:  state_q <= S_Q_DEG;
					S_Q_DEG: state_q <= S_Q_MID;
					S_Q_MID: begin
						// An empty search window ends the search without a match.
						state_q <= u_lt ? S_Q_CMP : S_FIN;
					end
					S_Q_CMP: begin
						state_q <= u_eq ? S_FIN : S_Q_MID;
					end
					S_FIN: begin
						if (out_load) begin
							state_q <= S_IDLE;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Working registers of the transaction in flight.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					bit_q  <= adj_bit;
					from_q <= from_node;
					key_q  <= to_node;
					has_q  <= 1'b0;
					outd_q <= '0;
					ind_q  <= '0;
					done_q <= 1'b0;
					if (func == FUNC_LOAD) begin
						status_q <= STATUS_OK;
					end else if (!graph_valid_q) begin
						status_q <= STATUS_NO_GRAPH;
					end else if (range_bad) begin
						status_q <= STATUS_RANGE;
					end else begin
						status_q <= STATUS_OK;
					end
				end
			end
			S_L_RD: begin
				// A set bit is dropped once the column store is full.
				store_ok_q <= bit_q && u_lt;
			end
			S_L_CNT: begin
				done_q <= row_wrap;
			end
			S_Q_HI: begin
				lo_q <= rs_rdata;
			end
			S_Q_DEG: begin
				hi_q   <= rs_rdata;
				ind_q  <= deg_rdata;
				outd_q <= u_res[EW-1:0];
			end
			S_Q_MID: begin
				mid_q <= u_res[EW-1:0];
			end
			S_Q_CMP: begin
				if (u_eq) begin
					has_q <= 1'b1;
				end else if (u_lt) begin
					lo_q <= u_res[EW-1:0];
				end else begin
					hi_q <= mid_q;
				end
			end
			default: begin
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Result register.
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= status_q;
			out_has_q    <= has_q;
			out_outd_q   <= DEG_W'(outd_q);
			out_ind_q    <= DEG_W'(ind_q);
			out_total_q  <= EDGE_TOTAL_W'(edge_count_q);
			out_done_q   <= done_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = out_status_q;
	assign has_edge   = out_has_q;
	assign out_degree = out_outd_q;
	assign in_degree  = out_ind_q;
	assign edge_total = out_total_q;
	assign load_done  = out_done_q;

	// ------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------
	a_edge_bound: assert property (@(posedge clk) disable iff (!arst_n)
		edge_count_q <= EW'(EDGE_CAP))
		else $error("edge count exceeds the column store size");

	a_graph_home: assert property (@(posedge clk) disable iff (!arst_n)
		graph_valid_q |-> (load_row_q == '0 && load_col_q == '0))
		else $error("complete graph flagged while the load position is away from the origin");

	a_search_window: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_Q_MID || state_q == S_Q_CMP) |-> (lo_q <= hi_q))
		else $error("binary search window inverted");

	a_edge_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_has_q) |-> (out_status_q == STATUS_OK))
		else $error("edge reported together with an error status");

endmodule

`default_nettype wire

>>> verif/csr_graph_builder_and_query_tb.sv
// Self-checking testbench for the CSR graph builder and query block.
// Holds its own graph predictor, stimulus tasks, result checker and watchdog.
// Depends on csrg_pkg and csr_graph_builder_and_query.
`timescale 1ns / 1ps

module csr_graph_builder_and_query_tb;
	import csrg_pkg::*;

	localparam int NODES           = MAX_NODES_DEF;
	localparam int EDGES           = EDGE_CAP_DEF;
	localparam int ITEM_TARGET     = 1550;
	// Past this many transactions neither side idles any more.
	localparam int QUIET_FROM      = 1400;
	localparam int HOLD_CYCLES     = 500;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int SETTLE_CYCLES   = 4;
	localparam int DRAIN_CYCLES    = 40;
	localparam logic [ADDR_W-1:0] NODE_COUNT_ADDR = {REG_NODE_COUNT, 2'b00};

	// One result transaction as the block should present it.
	typedef struct packed {
		logic [STATUS_W-1:0]     status;
		logic                    has_edge;
		logic [DEG_W-1:0]        out_degree;
		logic [DEG_W-1:0]        in_degree;
		logic [EDGE_TOTAL_W-1:0] edge_total;
		logic                    load_done;
	} graph_answer_t;

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    psel;
	logic                    penable;
	logic                    pwrite;
	logic [ADDR_W-1:0]       paddr;
	logic [DATA_W-1:0]       pwdata;
	logic [DATA_W-1:0]       prdata;
	logic                    pready;
	logic                    in_valid;
	logic                    in_ready;
	logic                    func;
	logic                    adj_bit;
	logic [NODE_W-1:0]       from_node;
	logic [NODE_W-1:0]       to_node;
	logic                    out_valid;
	logic                    out_ready;
	logic [STATUS_W-1:0]     status;
	logic                    has_edge;
	logic [DEG_W-1:0]        out_degree;
	logic [DEG_W-1:0]        in_degree;
	logic [EDGE_TOTAL_W-1:0] edge_total;
	logic                    load_done;

	// Predictor state: a private copy of the register and the graph stores.
	logic [COUNT_W-1:0]      node_count_reg = NODE_COUNT_RST;
	logic [EDGE_TOTAL_W-1:0] row_first [0:NODES];
	logic [NODE_W-1:0]       col_list [0:EDGES-1];
	logic [DEG_W-1:0]        in_cnt [0:NODES-1];
	int unsigned             cur_row = 0;
	int unsigned             cur_col = 0;
	logic [EDGE_TOTAL_W-1:0] edges_seen = '0;
	logic                    graph_ready = 1'b0;

	// Results still owed by the block, oldest first.
	graph_answer_t pending_answers [$];

	// Traffic shaping shared between the stimulus and the result sink.
	logic idle_on;
	int   holds_asked = 0;
	int   holds_served = 0;

	// Run statistics.
	int fail_count = 0;
	int items_sent = 0;
	int loads_sent = 0;
	int queries_sent = 0;
	int graphs_built = 0;
	int no_graph_answers = 0;
	int range_answers = 0;
	int writes_done = 0;
	int quiet_cycles = 0;

	csr_graph_builder_and_query #(
		.MAX_NODES(NODES),
		.EDGE_CAP (EDGES)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.adj_bit   (adj_bit),
		.from_node (from_node),
		.to_node   (to_node),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.has_edge  (has_edge),
		.out_degree(out_degree),
		.in_degree (in_degree),
		.edge_total(edge_total),
		.load_done (load_done)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// The register holds seven bits, but the graph logic clamps it: zero behaves as a
	// single node and anything above the store size behaves as the full store.
	function automatic int unsigned nodes_in_use();
		if (node_count_reg == '0) return 1;
		if (node_count_reg > NODES) return NODES;
		return node_count_reg;
	endfunction

	// Matrix bits still needed to finish the graph that is being loaded, or a fresh
	// one when the last graph is complete.
	function automatic int unsigned remaining_bits();
		int unsigned n;
		n = nodes_in_use();
		return n * n - (cur_row * n + cur_col);
	endfunction

	// A register write drops whatever load is under way and invalidates the graph.
	function automatic void apply_node_count(input logic [DATA_W-1:0] word);
		node_count_reg = word[COUNT_W-1:0];
		cur_row = 0;
		cur_col = 0;
		edges_seen = '0;
		graph_ready = 1'b0;
	endfunction

	// Advances the graph copy by one accepted transaction and returns its result.
	function automatic graph_answer_t predict_answer(input logic f, input logic bit_in,
			input logic [NODE_W-1:0] src, input logic [NODE_W-1:0] dst);
		graph_answer_t ans;
		int unsigned n, lo, hi, mid;
		ans = '0;
		n = nodes_in_use();
		if (f == FUNC_LOAD) begin
			if (cur_row >= n || cur_col >= n) begin
				cur_row = 0;
				cur_col = 0;
			end
			// The first bit of a matrix throws the previous graph away.
			if (cur_row == 0 && cur_col == 0) begin
				foreach (in_cnt[i]) in_cnt[i] = '0;
				edges_seen = '0;
				graph_ready = 1'b0;
			end
			if (cur_col == 0) row_first[cur_row] = edges_seen;
			// Set bits beyond the edge store capacity are silently dropped.
			if (bit_in && edges_seen < EDGES) begin
				col_list[edges_seen] = NODE_W'(cur_col);
				edges_seen = edges_seen + 1'b1;
				in_cnt[cur_col] = in_cnt[cur_col] + 1'b1;
			end
			cur_col++;
			if (cur_col >= n) begin
				cur_col = 0;
				cur_row++;
				if (cur_row >= n) begin
					row_first[n] = edges_seen;
					cur_row = 0;
					graph_ready = 1'b1;
					ans.load_done = 1'b1;
				end
			end
		end else if (!graph_ready) begin
			ans.status = STATUS_NO_GRAPH;
		end else if (src >= n || dst >= n) begin
			ans.status = STATUS_RANGE;
		end else begin
			lo = row_first[src];
			hi = row_first[src + 1];
			ans.out_degree = DEG_W'(hi - lo);
			ans.in_degree = in_cnt[src];
			// Columns within a row are stored in ascending order.
			while (lo < hi && !ans.has_edge) begin
				mid = lo + (hi - lo) / 2;
				if (mid >= EDGES) break;
				if (col_list[mid] == dst) ans.has_edge = 1'b1;
				else if (col_list[mid] < dst) lo = mid + 1;
				else hi = mid;
			end
		end
		ans.edge_total = edges_seen;
		return ans;
	endfunction

	function automatic void check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			fail_count++;
			if (fail_count <= 50)
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		end
	endfunction

	// Everything is observed at the rising edge. The predictor runs when a transaction
	// is accepted, so expectations are queued in the order the block takes them, and
	// every result transaction is matched against the oldest expectation. A register
	// write updates the predictor at the same edge at which the block takes it.
	always @(posedge clk) begin : result_check
		graph_answer_t want;
		if (arst_n) begin
			quiet_cycles++;
			if (psel && penable && pready) begin
				quiet_cycles = 0;
				if (pwrite && paddr == NODE_COUNT_ADDR) apply_node_count(pwdata);
			end
			if (in_valid && in_ready) begin
				quiet_cycles = 0;
				pending_answers.push_back(predict_answer(func, adj_bit, from_node, to_node));
			end
			if (out_valid && out_ready) begin
				quiet_cycles = 0;
				if (pending_answers.size() == 0) begin
					fail_count++;
					$display("%0t: result transaction with nothing outstanding, expected none, got status %0d",
						$time, status);
				end else begin
					want = pending_answers.pop_front();
					check_field("status", want.status, status);
					check_field("has_edge", want.has_edge, has_edge);
					check_field("out_degree", want.out_degree, out_degree);
					check_field("in_degree", want.in_degree, in_degree);
					check_field("edge_total", want.edge_total, edge_total);
					check_field("load_done", want.load_done, load_done);
					if (want.load_done) graphs_built++;
					if (want.status == STATUS_NO_GRAPH) no_graph_answers++;
					if (want.status == STATUS_RANGE) range_answers++;
				end
			end
			// A hung handshake on any channel ends the run here.
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no transaction for %0d cycles, %0d results outstanding",
					$time, quiet_cycles, pending_answers.size());
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Result sink. It normally takes every result, stalls in random bursts while idling
	// is enabled, and serves each long hold-off that a test asks for by counting the
	// cycles itself, so the sender keeps pushing while the block backs up.
	initial begin : result_sink
		out_ready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			if (holds_served != holds_asked) begin
				out_ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				holds_served++;
			end else if (idle_on && items_sent < QUIET_FROM && $urandom_range(0, 4) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 12)) @(negedge clk);
			end else begin
				out_ready = 1'b1;
				@(negedge clk);
			end
		end
	end

	// Offers one transaction and returns at the falling edge after it was accepted,
	// with valid still high. The caller either offers the next one at once or drops
	// valid; no rising edge passes in between.
	task automatic send_item(input logic f, input logic bit_in,
			input logic [NODE_W-1:0] src, input logic [NODE_W-1:0] dst);
		if (idle_on && items_sent < QUIET_FROM && $urandom_range(0, 4) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		in_valid = 1'b1;
		func = f;
		adj_bit = bit_in;
		from_node = src;
		to_node = dst;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		items_sent++;
		if (f == FUNC_LOAD) loads_sent++;
		else queries_sent++;
	endtask

	// Node fields are meaningless on a load, so they carry random noise.
	task automatic send_load(input logic bit_in);
		send_item(FUNC_LOAD, bit_in, NODE_W'($urandom), NODE_W'($urandom));
	endtask

	task automatic send_query(input logic [NODE_W-1:0] src, input logic [NODE_W-1:0] dst);
		send_item(FUNC_QUERY, 1'($urandom), src, dst);
	endtask

	// Drops valid and waits until every result has come back.
	task automatic wait_idle();
		in_valid = 1'b0;
		while (pending_answers.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes node_count with random upper bits, then reads it back. The block must be
	// idle, so outstanding results are drained first.
	task automatic program_node_count(input logic [COUNT_W-1:0] value);
		logic [DATA_W-1:0] got;
		wait_idle();
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = NODE_COUNT_ADDR;
		pwdata = {(DATA_W-COUNT_W)'($urandom), value};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		pwrite = 1'b0;
		penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		got = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		check_field("prdata", {{(DATA_W-COUNT_W){1'b0}}, node_count_reg}, got);
		writes_done++;
	endtask

	// Sends matrix bits at the given density, with stray queries mixed in when asked.
	task automatic load_graph(input int unsigned bits, input int unsigned pct,
			input logic mix_queries);
		for (int unsigned i = 0; i < bits; i++) begin
			if (mix_queries && $urandom_range(0, 24) == 0)
				send_query(NODE_W'($urandom), NODE_W'($urandom));
			send_load($urandom_range(0, 99) < pct);
		end
	endtask

	// Mostly valid node pairs, with one of the two nodes anywhere in its field now and then.
	task automatic run_queries(input int unsigned count);
		int unsigned n, r;
		logic [NODE_W-1:0] src, dst;
		n = nodes_in_use();
		for (int unsigned i = 0; i < count; i++) begin
			r = $urandom_range(0, 9);
			src = NODE_W'($urandom_range(0, n - 1));
			dst = NODE_W'($urandom_range(0, n - 1));
			if (r == 8) src = NODE_W'($urandom);
			else if (r == 9) dst = NODE_W'($urandom);
			send_query(src, dst);
		end
	endtask

	// The register is written with its reset value of 64 and read back, and queries see no graph yet.
	task automatic test_after_reset();
		wait_idle();
		program_node_count(NODE_COUNT_RST);
		send_query('0, '0);
		send_query('1, '1);
	endtask

	// One node: the smallest graph, its self loop, queries out of range and a reload without the loop.
	task automatic test_single_node();
		program_node_count(7'd1);
		send_load(1'b1);
		send_query(6'd0, 6'd0);
		send_query(6'd0, 6'd63);
		send_query(6'd1, 6'd0);
		send_load(1'b0);
		send_query(6'd0, 6'd0);
	endtask

	// Zero is clamped up to one node, the top register value down to the store size.
	// A query just after the large load starts reports the missing graph, although its
	// nodes are in range.
	task automatic test_count_limits();
		program_node_count(7'd0);
		send_load(1'b1);
		send_query(6'd0, 6'd0);
		program_node_count(7'd127);
		send_load(1'b1);
		send_load(1'b1);
		send_query(6'd63, 6'd0);
	endtask

	// Rewriting the same count drops a half-done load; a later load start drops a
	// complete graph, and queries meanwhile see no graph.
	task automatic test_abandon_and_reload();
		program_node_count(7'd2);
		send_load(1'b1);
		send_load(1'b1);
		program_node_count(7'd2);
		load_graph(4, 100, 1'b0);
		send_query(6'd0, 6'd1);
		send_query(6'd1, 6'd1);
		send_load(1'b0);
		send_query(6'd0, 6'd0);
		load_graph(3, 0, 1'b0);
		send_query(6'd1, 6'd1);
	endtask

	// The sink holds off for a long stretch while a whole graph and its queries are
	// offered, so the result register and the sequencer fill and input stalls.
	task automatic test_back_pressure();
		program_node_count(7'd4);
		holds_asked++;
		load_graph(remaining_bits(), 50, 1'b0);
		run_queries(12);
		wait_idle();
	endtask

	// Phases of random node counts and densities. Most phases load a complete matrix
	// and query it; some abandon a load midway, some keep the count and reload, and a
	// few work on partial loads of large graphs that are never finished.
	task automatic test_random_traffic();
		int unsigned pick, n, pct, r;
		while (items_sent < ITEM_TARGET) begin
			idle_on = ($urandom_range(0, 3) != 0);
			pick = $urandom_range(0, 19);
			if (pick == 0) program_node_count(COUNT_W'($urandom_range(64, 127)));
			else if (pick == 1) program_node_count(7'd0);
			else if (pick < 5) program_node_count(COUNT_W'($urandom_range(9, 16)));
			else if (pick < 14) program_node_count(COUNT_W'($urandom_range(1, 8)));
			n = nodes_in_use();
			r = $urandom_range(0, 5);
			pct = (r == 0) ? 0 : (r == 1) ? 100 : $urandom_range(5, 95);
			if (n > 16) begin
				load_graph($urandom_range(1, 60), pct, 1'b1);
				run_queries($urandom_range(2, 6));
			end else begin
				if (remaining_bits() > 1 && $urandom_range(0, 7) == 0) begin
					load_graph($urandom_range(1, remaining_bits() - 1), pct, 1'b1);
					program_node_count(node_count_reg);
				end
				load_graph(remaining_bits(), pct, 1'b1);
				run_queries(2 * n + $urandom_range(0, 8));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		func = FUNC_LOAD;
		adj_bit = 1'b0;
		from_node = '0;
		to_node = '0;
		idle_on = 1'b0;
		foreach (in_cnt[i]) in_cnt[i] = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_after_reset();
		test_single_node();
		test_count_limits();
		test_abandon_and_reload();
		test_back_pressure();
		test_random_traffic();

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (pending_answers.size() != 0) begin
			fail_count++;
			$display("%0t: results left outstanding, expected 0, got %0d",
				$time, pending_answers.size());
		end
		$display("Run sent %0d transactions: %0d matrix bits and %0d queries, %0d graphs completed.",
			items_sent, loads_sent, queries_sent, graphs_built);
		$display("Saw %0d queries without a graph, %0d out of range, across %0d register writes.",
			no_graph_answers, range_answers, writes_done);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
